### hdl/ias_pkg.sv
package ias_pkg;

    // Field widths of the block's ports.
    localparam int SAMPLE_W   = 16;
    localparam int AXIS_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default number of fraction bits of the axis value.
    localparam int FRAC_BITS_DEF = 16;

    // Movement mode divides by frame time times this factor.
    localparam int MOVE_DIVISOR = 7500;

    // Divisor is at most 65535 * 7500, which needs 29 bits.
    localparam int DIV_W  = 29;
    localparam int QUOT_W = 24;

    localparam logic signed [AXIS_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [AXIS_W-1:0] OUT_MIN = 24'sh800000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 3'd4;

    // Mode codes.
    localparam logic [1:0] MODE_AXIS   = 2'd0;
    localparam logic [1:0] MODE_BUTTON = 2'd1;
    localparam logic [1:0] MODE_MOVE   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [15:0] RATE_RST = 16'd768;

    typedef struct packed {
        logic capture;
        logic mul;
        logic raw;
        logic eval;
        logic div_step;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_status;

endpackage

### hdl/ias_ctrl.sv
module ias_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_stall,
    input  ias_pkg::t_dp_status   i_status,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output ias_pkg::t_ctrl_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RAW  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int CNT_W = $clog2(ias_pkg::QUOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ias_pkg::QUOT_W - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RAW;
            end
            S_RAW: begin
                o_cmd.raw = 1'b1;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_cnt      = '0;
                n_state    = i_status.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // The result waits here until the output register is free.
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/ias_datapath.sv
module ias_datapath #(
    parameter int FRAC_BITS = ias_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ias_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ias_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_button_pos,
    input  logic                                  i_button_alt_pos,
    input  logic                                  i_button_neg,
    input  logic                                  i_button_alt_neg,
    input  logic signed [ias_pkg::SAMPLE_W-1:0]   i_stick_sample,
    input  logic signed [ias_pkg::SAMPLE_W-1:0]   i_mouse_delta,
    input  logic [ias_pkg::SAMPLE_W-1:0]          i_delta_time,
    input  ias_pkg::t_ctrl_cmd                    i_cmd,
    output ias_pkg::t_dp_status                   o_status,
    output logic signed [ias_pkg::AXIS_W-1:0]     o_axis_value,
    output logic signed [ias_pkg::AXIS_W-1:0]     o_raw_value,
    output logic                                  o_saturated
);

    localparam int AXIS_W  = ias_pkg::AXIS_W;
    localparam int DIV_W   = ias_pkg::DIV_W;
    localparam int QUOT_W  = ias_pkg::QUOT_W;
    // Movement raw value is |delta * sensitivity| < 2^31 scaled by 2^(FRAC_BITS-8).
    localparam int RAW_W   = FRAC_BITS + 24;
    localparam int MAG_W   = FRAC_BITS + 23;
    localparam int STEP_SH = 24 - FRAC_BITS;
    localparam int STEP_W  = 32 - STEP_SH;
    localparam int SUM_W   = ((STEP_W + 1 > AXIS_W) ? STEP_W + 1 : AXIS_W) + 1;
    localparam int TOP_W   = MAG_W - 8;
    localparam int CMP_W   = (TOP_W > DIV_W) ? TOP_W : DIV_W;

    localparam logic signed [RAW_W-1:0] ONE_R = RAW_W'(2 ** FRAC_BITS);
    localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(2 ** FRAC_BITS);

    // Configuration registers.
    logic [1:0]  r_mode;
    logic        r_invert;
    logic [15:0] r_dead_zone;
    logic [15:0] r_gravity;
    logic [15:0] r_sensitivity;

    // Captured transaction.
    logic                       r_btn_p, r_btn_n;
    logic signed [15:0]         r_stick, r_mouse;
    logic [15:0]                r_dt;

    // Products.
    logic signed [31:0]         r_prod;
    logic [DIV_W-1:0]           r_divisor;
    logic [STEP_W-1:0]          r_step_g, r_step_s;

    // Raw value and its magnitude.
    logic signed [RAW_W-1:0]    r_raw;
    logic [MAG_W-1:0]           r_mag;

    // Evaluation results and divider.
    logic signed [AXIS_W-1:0]   r_next_axis, n_next_axis;
    logic                       r_sat, n_sat;
    logic signed [AXIS_W-1:0]   r_raw_out;
    logic                       r_need_div, n_need_div;
    logic                       r_neg;
    logic [DIV_W-1:0]           r_rem;
    logic [QUOT_W-1:0]          r_low, r_quot;

    logic signed [AXIS_W-1:0]   r_axis;

    // Multiplier stage.
    logic signed [32:0]         prod_full;
    logic [DIV_W-1:0]           div_full;
    logic [31:0]                grav_full, sens_full;

    assign prod_full = r_mouse * $signed({1'b0, r_sensitivity});
    assign div_full  = DIV_W'(r_dt) * DIV_W'(ias_pkg::MOVE_DIVISOR);
    assign grav_full = 32'(r_gravity) * 32'(r_dt);
    assign sens_full = 32'(r_sensitivity) * 32'(r_dt);

    // Raw stage.
    logic signed [FRAC_BITS+15:0] stick_q;
    logic signed [RAW_W-1:0]      pre_move;
    logic signed [RAW_W-1:0]      pre_btn;
    logic signed [RAW_W-1:0]      pre;
    logic signed [RAW_W-1:0]      pre_neg;

    assign stick_q  = $signed({r_stick, {FRAC_BITS{1'b0}}}) >>> 15;
    assign pre_move = RAW_W'(r_prod) <<< (FRAC_BITS - 8);
    assign pre_btn  = (r_btn_p ? ONE_R : '0) - (r_btn_n ? ONE_R : '0);
    assign pre_neg  = -pre;

    always_comb begin
        unique case (r_mode)
            ias_pkg::MODE_AXIS:   pre = RAW_W'(stick_q);
            ias_pkg::MODE_BUTTON: pre = pre_btn;
            ias_pkg::MODE_MOVE:   pre = pre_move;
            ias_pkg::MODE_NONE:   pre = '0;
            default:              pre = '0;
        endcase
    end

    // Evaluation stage.
    logic [FRAC_BITS+15:0]      dz_wide;
    logic [FRAC_BITS-1:0]       dead;
    logic                       below_dead, atmost_dead;
    logic                       raw_neg, raw_pos, mag_zero;
    logic [RAW_W-AXIS_W:0]      raw_top;
    logic                       raw_fits;
    logic signed [AXIS_W-1:0]   raw_sat;
    logic                       ovf;
    logic signed [SUM_W-1:0]    st_w, sg, ss;
    logic signed [SUM_W-1:0]    dec_dn, dec_up, ramp_up, ramp_dn, btn_next;

    assign dz_wide     = {r_dead_zone, {FRAC_BITS{1'b0}}};
    assign dead        = dz_wide[FRAC_BITS+15:16];
    assign below_dead  = r_mag <  MAG_W'(dead);
    assign atmost_dead = r_mag <= MAG_W'(dead);
    assign raw_neg     = r_raw[RAW_W-1];
    assign mag_zero    = (r_mag == '0);
    assign raw_pos     = !raw_neg && !mag_zero;

    assign raw_top  = r_raw[RAW_W-1:AXIS_W-1];
    assign raw_fits = (&raw_top) || !(|raw_top);
    assign raw_sat  = raw_fits ? r_raw[AXIS_W-1:0]
                    : (raw_neg ? ias_pkg::OUT_MIN : ias_pkg::OUT_MAX);

    // Quotient reaches 2^24 exactly when the top of the dividend reaches the divisor.
    assign ovf = CMP_W'(r_mag >> 8) >= CMP_W'(r_divisor);

    assign st_w    = SUM_W'(r_axis);
    assign sg      = $signed(SUM_W'(r_step_g));
    assign ss      = $signed(SUM_W'(r_step_s));
    assign dec_dn  = st_w - sg;
    assign dec_up  = st_w + sg;
    assign ramp_up = st_w + ss;
    assign ramp_dn = st_w - ss;

    always_comb begin
        btn_next = st_w;
        if (atmost_dead) begin
            if (st_w > 0) begin
                btn_next = (dec_dn < 0) ? '0 : dec_dn;
            end else if (st_w < 0) begin
                btn_next = (dec_up > 0) ? '0 : dec_up;
            end
        end else begin
            btn_next = raw_pos ? ramp_up : ramp_dn;
            if (btn_next > ONE_S) begin
                btn_next = ONE_S;
            end else if (btn_next < -ONE_S) begin
                btn_next = -ONE_S;
            end
        end
    end

    always_comb begin
        n_next_axis = r_axis;
        n_sat       = !raw_fits;
        n_need_div  = 1'b0;
        unique case (r_mode)
            ias_pkg::MODE_AXIS: begin
                n_next_axis = below_dead ? '0 : raw_sat;
            end
            ias_pkg::MODE_BUTTON: begin
                n_next_axis = AXIS_W'(btn_next);
            end
            ias_pkg::MODE_MOVE: begin
                if (below_dead || mag_zero) begin
                    n_next_axis = '0;
                end else if (r_dt == '0) begin
                    n_sat       = 1'b1;
                    n_next_axis = raw_neg ? ias_pkg::OUT_MIN : ias_pkg::OUT_MAX;
                end else if (ovf) begin
                    // A large negative quotient clamps to the lower limit unflagged.
                    n_next_axis = raw_neg ? ias_pkg::OUT_MIN : ias_pkg::OUT_MAX;
                    n_sat       = n_sat || !raw_neg;
                end else begin
                    n_need_div = 1'b1;
                end
            end
            ias_pkg::MODE_NONE: begin
                n_next_axis = r_axis;
            end
            default: begin
                n_next_axis = r_axis;
            end
        endcase
    end

    assign o_status.need_div = n_need_div;

    // Restoring division step.
    logic [DIV_W:0]  trial_shift;
    logic [DIV_W:0]  trial_diff;
    logic            trial_ge;

    assign trial_shift = {r_rem, r_low[QUOT_W-1]};
    assign trial_diff  = trial_shift - {1'b0, r_divisor};
    assign trial_ge    = trial_shift >= {1'b0, r_divisor};

    // Final movement result from the quotient.
    logic                       q_big;
    logic signed [AXIS_W-1:0]   div_val;
    logic                       div_sat;
    logic signed [AXIS_W-1:0]   axis_new;

    assign q_big = r_quot[QUOT_W-1];

    always_comb begin
        if (!r_neg) begin
            div_val = q_big ? ias_pkg::OUT_MAX : $signed(r_quot);
            div_sat = q_big;
        end else begin
            div_val = q_big ? ias_pkg::OUT_MIN : -$signed(r_quot);
            div_sat = 1'b0;
        end
    end

    assign axis_new = r_need_div ? div_val : r_next_axis;

    // Configuration and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ias_pkg::MODE_AXIS;
            r_invert      <= 1'b0;
            r_dead_zone   <= '0;
            r_gravity     <= ias_pkg::RATE_RST;
            r_sensitivity <= ias_pkg::RATE_RST;
            r_axis        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ias_pkg::CFG_MODE:        r_mode        <= i_cfg_data[1:0];
                    ias_pkg::CFG_INVERT:      r_invert      <= i_cfg_data[0];
                    ias_pkg::CFG_DEAD_ZONE:   r_dead_zone   <= i_cfg_data;
                    ias_pkg::CFG_GRAVITY:     r_gravity     <= i_cfg_data;
                    ias_pkg::CFG_SENSITIVITY: r_sensitivity <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_axis <= axis_new;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_btn_p <= i_button_pos || i_button_alt_pos;
            r_btn_n <= i_button_neg || i_button_alt_neg;
            r_stick <= i_stick_sample;
            r_mouse <= i_mouse_delta;
            r_dt    <= i_delta_time;
        end
        if (i_cmd.mul) begin
            r_prod    <= prod_full[31:0];
            r_divisor <= div_full;
            r_step_g  <= grav_full[31:STEP_SH];
            r_step_s  <= sens_full[31:STEP_SH];
        end
        if (i_cmd.raw) begin
            r_raw <= r_invert ? pre_neg : pre;
            r_mag <= pre[RAW_W-1] ? pre_neg[MAG_W-1:0] : pre[MAG_W-1:0];
        end
        if (i_cmd.eval) begin
            r_next_axis <= n_next_axis;
            r_sat       <= n_sat;
            r_raw_out   <= raw_sat;
            r_need_div  <= n_need_div;
            r_neg       <= raw_neg;
            r_rem       <= DIV_W'(r_mag >> 8);
            r_low       <= {r_mag[7:0], 16'd0};
            r_quot      <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? trial_diff[DIV_W-1:0] : trial_shift[DIV_W-1:0];
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], trial_ge};
        end
        if (i_cmd.commit) begin
            o_axis_value <= axis_new;
            o_raw_value  <= r_raw_out;
            o_saturated  <= r_sat || (r_need_div && div_sat);
        end
    end

endmodule

### hdl/input_axis_smoother_core.sv
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      buttons, stick sample, mouse delta, frame time
// output    out        o_out_valid / i_out_stall    axis value, raw value, saturated flag
// config    in         i_cfg_valid / o_cfg_ready    register index, write data
//
// An item passes from the capture through the multiply, raw and evaluate states; in movement
// mode it may also run the radix-2 restoring divider, which adds one quotient bit per cycle
// until all 24 quotient bits are formed. The result is then loaded into the output register.
// One item is in work at a time; the input is accepted again once its result is loaded
// into the output register, even while that result is still stalled. A stalled result
// keeps the next one waiting in its done state. Reset is synchronous and active low.
module input_axis_smoother_core #(
    parameter int FRAC_BITS = ias_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ias_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ias_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_button_pos,
    input  logic                                  i_button_alt_pos,
    input  logic                                  i_button_neg,
    input  logic                                  i_button_alt_neg,
    input  logic signed [ias_pkg::SAMPLE_W-1:0]   i_stick_sample,
    input  logic signed [ias_pkg::SAMPLE_W-1:0]   i_mouse_delta,
    input  logic [ias_pkg::SAMPLE_W-1:0]          i_delta_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ias_pkg::AXIS_W-1:0]     o_axis_value,
    output logic signed [ias_pkg::AXIS_W-1:0]     o_raw_value,
    output logic                                  o_saturated
);

    ias_pkg::t_ctrl_cmd  cmd;
    ias_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    ias_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ias_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_button_pos     (i_button_pos),
        .i_button_alt_pos (i_button_alt_pos),
        .i_button_neg     (i_button_neg),
        .i_button_alt_neg (i_button_alt_neg),
        .i_stick_sample   (i_stick_sample),
        .i_mouse_delta    (i_mouse_delta),
        .i_delta_time     (i_delta_time),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_axis_value     (o_axis_value),
        .o_raw_value      (o_raw_value),
        .o_saturated      (o_saturated)
    );

endmodule

### hdl/ias_checker.sv
module ias_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic [ias_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input logic [ias_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  i_button_pos,
    input logic                                  i_button_alt_pos,
    input logic                                  i_button_neg,
    input logic                                  i_button_alt_neg,
    input logic signed [ias_pkg::SAMPLE_W-1:0]   i_stick_sample,
    input logic signed [ias_pkg::SAMPLE_W-1:0]   i_mouse_delta,
    input logic [ias_pkg::SAMPLE_W-1:0]          i_delta_time,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [ias_pkg::AXIS_W-1:0]     o_axis_value,
    input logic signed [ias_pkg::AXIS_W-1:0]     o_raw_value,
    input logic                                  o_saturated
);

    logic in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    // One transaction at a time, and its result never appears in the next cycle.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall && !$rose(o_out_valid))
        else $error("input taken again or result too early");

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_axis_value) && $stable(o_raw_value)
            && $stable(o_saturated))
        else $error("stalled result changed");

    // The block frees its input only after loading a result.
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("input freed without a result");

    // The flag marks a value pinned at one of the limits.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_axis_value == ias_pkg::OUT_MAX || o_axis_value == ias_pkg::OUT_MIN
            || o_raw_value == ias_pkg::OUT_MAX || o_raw_value == ias_pkg::OUT_MIN)
        else $error("saturated flag without a clipped value");

endmodule

bind input_axis_smoother_core ias_checker u_ias_checker (.*);

### tb/input_axis_smoother_core_tb.sv
module input_axis_smoother_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RUN_LIMIT     = 400000;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     LONG_HOLD     = 300;
    localparam int     RANDOM_PHASES = 16;
    localparam int     PHASE_TICKS   = 95;
    localparam int     SAMPLE_W      = ias_pkg::SAMPLE_W;
    localparam int     AXIS_W        = ias_pkg::AXIS_W;
    localparam int     CFG_IDX_W     = ias_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W    = ias_pkg::CFG_DATA_W;
    localparam int     FRAC_BITS_DEF = ias_pkg::FRAC_BITS_DEF;
    localparam longint AXIS_HI       = ias_pkg::OUT_MAX;
    localparam longint AXIS_LO       = ias_pkg::OUT_MIN;
    localparam longint UNIT          = 1 << FRAC_BITS_DEF;

    typedef struct packed {
        logic                btn_pos;
        logic                btn_alt_pos;
        logic                btn_neg;
        logic                btn_alt_neg;
        logic [SAMPLE_W-1:0] stick;
        logic [SAMPLE_W-1:0] mouse;
        logic [SAMPLE_W-1:0] dt;
    } t_tick;

    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic [AXIS_W-1:0] raw;
        logic              sat;
    } t_axis_out;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data       = '0;
    logic                         i_in_valid       = 1'b0;
    logic                         i_button_pos     = 1'b0;
    logic                         i_button_alt_pos = 1'b0;
    logic                         i_button_neg     = 1'b0;
    logic                         i_button_alt_neg = 1'b0;
    logic signed [SAMPLE_W-1:0]   i_stick_sample   = '0;
    logic signed [SAMPLE_W-1:0]   i_mouse_delta    = '0;
    logic [SAMPLE_W-1:0]          i_delta_time     = '0;
    logic                         i_out_stall      = 1'b0;
    logic                         o_cfg_ready;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic signed [AXIS_W-1:0]     o_axis_value;
    logic signed [AXIS_W-1:0]     o_raw_value;
    logic                         o_saturated;

    // Shadow copy of the block's registers and its persistent axis value.
    logic [1:0]  cfg_mode        = ias_pkg::MODE_AXIS;
    logic        cfg_invert      = 1'b0;
    logic [15:0] cfg_dead_zone   = '0;
    logic [15:0] cfg_gravity     = ias_pkg::RATE_RST;
    logic [15:0] cfg_sensitivity = ias_pkg::RATE_RST;
    longint      axis_track      = 0;

    t_axis_out   axis_expect[$];
    logic [3:0]  held_buttons    = '0;
    logic [1:0]  mode_order[4]   = '{ias_pkg::MODE_AXIS, ias_pkg::MODE_BUTTON,
                                     ias_pkg::MODE_MOVE, ias_pkg::MODE_NONE};
    int          send_idle_pct   = 0;
    int          out_stall_pct   = 0;
    logic        out_hold        = 1'b0;
    int          fail_count      = 0;
    int          ticks_sent      = 0;
    int          config_phases   = 0;
    int          cycle_count     = 0;
    event        out_hold_start;

    input_axis_smoother_core #(
        .FRAC_BITS(FRAC_BITS_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_button_pos    (i_button_pos),
        .i_button_alt_pos(i_button_alt_pos),
        .i_button_neg    (i_button_neg),
        .i_button_alt_neg(i_button_alt_neg),
        .i_stick_sample  (i_stick_sample),
        .i_mouse_delta   (i_mouse_delta),
        .i_delta_time    (i_delta_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_axis_value    (o_axis_value),
        .o_raw_value     (o_raw_value),
        .o_saturated     (o_saturated)
    );

    always begin
        #1 i_clk = 1'b0;
        #1 i_clk = 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > AXIS_HI) return AXIS_HI;
        if (v < AXIS_LO) return AXIS_LO;
        return v;
    endfunction

    // Advances the shadow axis value by one frame tick and returns the result it yields.
    function automatic t_axis_out predict_tick(input t_tick t);
        t_axis_out r;
        longint    raw;
        longint    dead;
        longint    dt_v;
        longint    sample_v;
        longint    step;
        longint    q;
        logic      clip;
        logic      p;
        logic      n;
        clip = 1'b0;
        raw  = 0;
        dead = cfg_dead_zone;
        dt_v = t.dt;
        case (cfg_mode)
            ias_pkg::MODE_AXIS: begin
                sample_v = $signed(t.stick);
                raw = sample_v * 2;     // Q1.15 to Q8.16
                if (cfg_invert) raw = -raw;
                if (mag64(raw) < dead) begin
                    axis_track = 0;
                end else begin
                    clip = clip | (clamp24(raw) != raw);
                    axis_track = clamp24(raw);
                end
            end
            ias_pkg::MODE_BUTTON: begin
                p = t.btn_pos | t.btn_alt_pos;
                n = t.btn_neg | t.btn_alt_neg;
                raw = (p ? UNIT : 0) - (n ? UNIT : 0);
                if (cfg_invert) raw = -raw;
                if (mag64(raw) <= dead) begin
                    step = (longint'(cfg_gravity) * dt_v) >> (24 - FRAC_BITS_DEF);
                    if (axis_track > 0) begin
                        axis_track = axis_track - step;
                        if (axis_track < 0) axis_track = 0;
                    end else if (axis_track < 0) begin
                        axis_track = axis_track + step;
                        if (axis_track > 0) axis_track = 0;
                    end
                end else begin
                    step = (longint'(cfg_sensitivity) * dt_v) >> (24 - FRAC_BITS_DEF);
                    axis_track = axis_track + ((raw > 0) ? step : -step);
                    if (axis_track > UNIT) axis_track = UNIT;
                    else if (axis_track < -UNIT) axis_track = -UNIT;
                end
            end
            ias_pkg::MODE_MOVE: begin
                sample_v = $signed(t.mouse);
                raw = sample_v * longint'(cfg_sensitivity) * 256;   // Q8.8 gain to Q8.16
                if (cfg_invert) raw = -raw;
                if (mag64(raw) < dead || raw == 0) begin
                    axis_track = 0;
                end else if (dt_v == 0) begin
                    clip = 1'b1;
                    axis_track = (raw > 0) ? AXIS_HI : AXIS_LO;
                end else begin
                    q = (mag64(raw) << 16) / (dt_v * ias_pkg::MOVE_DIVISOR);
                    if (q > AXIS_HI + 1) q = AXIS_HI + 1;
                    if (raw < 0) q = -q;
                    clip = clip | (clamp24(q) != q);
                    axis_track = clamp24(q);
                end
            end
            default: begin
            end
        endcase
        clip = clip | (clamp24(raw) != raw);
        raw = clamp24(raw);
        r.axis = axis_track[AXIS_W-1:0];
        r.raw  = raw[AXIS_W-1:0];
        r.sat  = clip;
        return r;
    endfunction

    // Output side: checks every accepted result, then picks the stall for the next cycle.
    always @(posedge i_clk) begin : out_check
        t_axis_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (axis_expect.size() == 0) begin
                $display("%0t: result with no pending tick: axis_value %0d raw_value %0d",
                         $time, o_axis_value, o_raw_value);
                fail_count++;
            end else begin
                want = axis_expect.pop_front();
                if (o_axis_value !== want.axis) begin
                    $display("%0t: axis_value expected %0d, got %0d",
                             $time, $signed(want.axis), o_axis_value);
                    fail_count++;
                end
                if (o_raw_value !== want.raw) begin
                    $display("%0t: raw_value expected %0d, got %0d",
                             $time, $signed(want.raw), o_raw_value);
                    fail_count++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated expected %0b, got %0b",
                             $time, want.sat, o_saturated);
                    fail_count++;
                end
            end
        end
        i_out_stall <= out_hold || ($urandom_range(99) < out_stall_pct);
    end

    // Long output hold, counted here so the sender keeps offering ticks meanwhile.
    initial begin : out_hold_counter
        forever begin
            @(out_hold_start);
            out_hold <= 1'b1;
            repeat (LONG_HOLD) @(posedge i_clk);
            out_hold <= 1'b0;
        end
    end

    function automatic t_tick make_tick(input logic [3:0] buttons, input logic [15:0] stick,
                                        input logic [15:0] mouse, input logic [15:0] dt);
        t_tick t;
        {t.btn_pos, t.btn_alt_pos, t.btn_neg, t.btn_alt_neg} = buttons;
        t.stick = stick;
        t.mouse = mouse;
        t.dt    = dt;
        return t;
    endfunction

    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h0000;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_mouse();
        logic [15:0] v;
        int          small_step;
        v = 16'($urandom);
        small_step = $urandom_range(400);
        case ($urandom_range(9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2, 3, 4, 5: v = 16'(small_step - 200);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_frame_time();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(9))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'h0001;
            3, 4, 5, 6, 7: v = 16'($urandom_range(3000, 200));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_rate();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(5))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2, 3: v = 16'($urandom_range(2048));
            default: ;
        endcase
        return v;
    endfunction

    // Buttons stay held for stretches so that ramps reach the clamp and gravity runs out.
    function automatic t_tick rand_tick();
        if ($urandom_range(99) < 15) held_buttons = 4'($urandom);
        return make_tick(held_buttons, pick_sample(), pick_mouse(), pick_frame_time());
    endfunction

    task automatic set_idle(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        out_stall_pct <= stall_pct;
    endtask

    task automatic send_tick(input t_tick t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_button_pos     <= t.btn_pos;
        i_button_alt_pos <= t.btn_alt_pos;
        i_button_neg     <= t.btn_neg;
        i_button_alt_neg <= t.btn_alt_neg;
        i_stick_sample   <= t.stick;
        i_mouse_delta    <= t.mouse;
        i_delta_time     <= t.dt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        axis_expect.push_back(predict_tick(t));
        ticks_sent++;
    endtask

    // Stops offering ticks until every pending result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (axis_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        // Shadow registers follow each accepted configuration transaction.
        case (idx)
            ias_pkg::CFG_MODE:        cfg_mode        = data[1:0];
            ias_pkg::CFG_INVERT:      cfg_invert      = data[0];
            ias_pkg::CFG_DEAD_ZONE:   cfg_dead_zone   = data;
            ias_pkg::CFG_GRAVITY:     cfg_gravity     = data;
            ias_pkg::CFG_SENSITIVITY: cfg_sensitivity = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic inv, input logic [15:0] dz,
                              input logic [15:0] grav, input logic [15:0] sens,
                              input bit spare_too);
        logic [15:0] word;
        drain_results();
        word = 16'($urandom);
        word[1:0] = mode;
        write_reg(ias_pkg::CFG_MODE, word);
        word = 16'($urandom);
        word[0] = inv;
        write_reg(ias_pkg::CFG_INVERT, word);
        write_reg(ias_pkg::CFG_DEAD_ZONE, dz);
        write_reg(ias_pkg::CFG_GRAVITY, grav);
        write_reg(ias_pkg::CFG_SENSITIVITY, sens);
        if (spare_too) begin
            for (int idx = ias_pkg::CFG_SENSITIVITY + 1; idx < (1 << CFG_IDX_W); idx++) begin
                word = 16'($urandom);
                write_reg(CFG_IDX_W'(idx), word);
            end
        end
        i_cfg_valid <= 1'b0;
        config_phases++;
    endtask

    task automatic test_reset_values();
        send_tick(make_tick(4'b0000, 16'h7FFF, 16'h0000, 16'h0000));
        send_tick(make_tick(4'b1111, 16'h8000, 16'h7FFF, 16'hFFFF));
        send_tick(make_tick(4'b0000, 16'h0000, 16'h8000, 16'h0001));
    endtask

    task automatic test_axis_mode();
        set_config(ias_pkg::MODE_AXIS, 1'b1, 16'h4000, ias_pkg::RATE_RST, ias_pkg::RATE_RST,
                   1'b1);
        // Just inside the dead zone, then exactly on its edge, then the negative extreme.
        send_tick(make_tick(4'b0000, 16'h1FFF, 16'h0000, 16'h0444));
        send_tick(make_tick(4'b0000, 16'h2000, 16'h0000, 16'h0444));
        send_tick(make_tick(4'b0000, 16'h8000, 16'h0000, 16'h0444));
    endtask

    task automatic test_button_mode();
        set_config(ias_pkg::MODE_BUTTON, 1'b0, 16'h0000, 16'hFFFF, ias_pkg::RATE_RST, 1'b0);
        send_tick(make_tick(4'b1000, 16'h0000, 16'h0000, 16'd1092));
        send_tick(make_tick(4'b0100, 16'h0000, 16'h0000, 16'hFFFF));
        send_tick(make_tick(4'b1010, 16'h0000, 16'h0000, 16'd1092));
        send_tick(make_tick(4'b0001, 16'h0000, 16'h0000, 16'hFFFF));
        send_tick(make_tick(4'b0000, 16'h0000, 16'h0000, 16'h0000));
        // Inverted, widest dead zone and no gravity: the negative button now ramps up.
        set_config(ias_pkg::MODE_BUTTON, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        send_tick(make_tick(4'b0010, 16'h0000, 16'h0000, 16'd10));
        send_tick(make_tick(4'b0000, 16'h0000, 16'h0000, 16'hFFFF));
    endtask

    task automatic test_movement_mode();
        set_config(ias_pkg::MODE_MOVE, 1'b0, 16'h0000, ias_pkg::RATE_RST, 16'hFFFF, 1'b0);
        // Zero frame time saturates toward the sign of the motion, or gives zero for none.
        send_tick(make_tick(4'b0000, 16'h0000, 16'h7FFF, 16'h0000));
        send_tick(make_tick(4'b0000, 16'h0000, 16'h8000, 16'h0000));
        send_tick(make_tick(4'b0000, 16'h0000, 16'h0000, 16'h0000));
        send_tick(make_tick(4'b0000, 16'h0000, 16'h0001, 16'hFFFF));
        send_tick(make_tick(4'b0000, 16'h0000, 16'h8000, 16'h0001));
        set_config(ias_pkg::MODE_MOVE, 1'b1, 16'hFFFF, ias_pkg::RATE_RST, 16'h0001, 1'b0);
        send_tick(make_tick(4'b0000, 16'h0000, 16'd255, 16'd1092));
        send_tick(make_tick(4'b0000, 16'h0000, 16'd256, 16'd1092));
    endtask

    // A value beyond one unit left by movement mode decays, or clamps once ramping.
    task automatic test_state_carryover();
        set_config(ias_pkg::MODE_MOVE, 1'b0, 16'h0000, ias_pkg::RATE_RST, 16'hFFFF, 1'b0);
        send_tick(make_tick(4'b0000, 16'h0000, 16'h7FFF, 16'h0000));
        set_config(ias_pkg::MODE_BUTTON, 1'b0, 16'h0000, 16'hFFFF, 16'h0001, 1'b0);
        send_tick(make_tick(4'b0000, 16'h0000, 16'h0000, 16'd100));
        set_config(ias_pkg::MODE_MOVE, 1'b0, 16'h0000, ias_pkg::RATE_RST, 16'hFFFF, 1'b0);
        send_tick(make_tick(4'b0000, 16'h0000, 16'h8000, 16'h0000));
        set_config(ias_pkg::MODE_BUTTON, 1'b0, 16'h0000, 16'hFFFF, 16'h0001, 1'b0);
        send_tick(make_tick(4'b1000, 16'h0000, 16'h0000, 16'h0001));
    endtask

    task automatic test_unused_mode();
        set_config(ias_pkg::MODE_NONE, 1'b1, pick_rate(), pick_rate(), pick_rate(), 1'b0);
        send_tick(rand_tick());
        send_tick(rand_tick());
    endtask

    // The output is held off while ticks keep coming, so the input must stall.
    task automatic test_long_output_hold();
        set_idle(0, 0);
        set_config(ias_pkg::MODE_BUTTON, 1'b0, 16'h0000, ias_pkg::RATE_RST,
                   ias_pkg::RATE_RST, 1'b0);
        -> out_hold_start;
        repeat (12) send_tick(rand_tick());
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ((p / 4) % 4)
                0: set_idle(0, 0);
                1: set_idle(60, 0);
                2: set_idle(0, 60);
                default: set_idle(12, 12);
            endcase
            set_config(mode_order[p % 4], 1'($urandom), pick_rate(), pick_rate(), pick_rate(),
                       1'b0);
            repeat (PHASE_TICKS) begin
                send_tick(rand_tick());
                if ($urandom_range(199) == 0) drain_results();
            end
        end
    endtask

    initial begin : run
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_axis_mode();
        test_button_mode();
        test_movement_mode();
        test_state_carryover();
        test_unused_mode();
        test_long_output_hold();
        test_random_phases();
        drain_results();
        $display("Run covered %0d ticks over %0d register settings in all four modes,",
                 ticks_sent, config_phases);
        $display("with sender gaps, output stalls, both, and one %0d-cycle output hold.",
                 LONG_HOLD);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
